[sv/mecanum_wheel_mixer_odometry_unit_defines.svh]
// Assertion macros for the mecanum mixer block.
`ifndef MECANUM_WHEEL_MIXER_ODOMETRY_UNIT_DEFINES_SVH
`define MECANUM_WHEEL_MIXER_ODOMETRY_UNIT_DEFINES_SVH

// Assert that prop holds on every clock edge outside reset.
`define MWMO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assert with no reset gating.
`define MWMO_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/mwmo_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mwmo_pkg;
  localparam int SineTableDepth = 256;
  localparam int TransW = 20;
  localparam int PeriodW = 16;
  localparam logic [19:0] TransReset = 20'd121677;
  localparam logic [19:0] RotReset = 20'd16426;
  localparam logic [15:0] PeriodReset = 16'd6554;
  localparam logic [1:0] RegTrans = 2'd0;
  localparam logic [1:0] RegRot = 2'd1;
  localparam logic [1:0] RegPeriod = 2'd2;
  localparam logic signed [31:0] TurnPerRad = 32'sd683565276;
  localparam logic [7:0] WheelMin = 8'd7;
  localparam logic [7:0] WheelMax = 8'd250;
  localparam logic [7:0] WheelOff = 8'd127;

  // Multiplier operand selection, one product per step.
  typedef enum logic [3:0] {
    MUL_IDLE = 4'b0000,
    MUL_TX   = 4'b0001,
    MUL_TY   = 4'b0010,
    MUL_R    = 4'b0011,
    MUL_CX   = 4'b0100,
    MUL_SY   = 4'b0101,
    MUL_SX   = 4'b0110,
    MUL_CY   = 4'b0111,
    MUL_GXP  = 4'b1000,
    MUL_GYP  = 4'b1001,
    MUL_WP   = 4'b1010,
    MUL_DH   = 4'b1011
  } mul_op_t;

  typedef struct packed {
    logic    load;
    mul_op_t op;
    logic    finish;
  } mwmo_cmd_t;

  // Q1.14 sine of a folded Q30 angle (0..pi/2), degree-11 Taylor series.
  // Evaluated at elaboration only.
  function automatic logic signed [15:0] sine_poly(input longint unsigned x,
                                                   input logic neg);
    longint unsigned x2, t, s;
    x2 = (x * x) >> 30;
    t = (64'd1 << 30) - x2 / 110;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 72;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
    s = (x * t) >> 30;
    s = (s + 64'd32768) >> 16;
    if (s > 64'd16384) s = 64'd16384;
    return neg ? -16'(s) : 16'(s);
  endfunction
endpackage
`default_nettype wire

[sv/mwmo_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module mwmo_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_fire,
  input  wire logic             out_free,
  output mwmo_pkg::mwmo_cmd_t   cmd,
  output logic                  busy
);
  import mwmo_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t  state, state_next;
  mul_op_t step, step_next;

  always_comb begin
    state_next = state;
    step_next = step;
    cmd = '{load: 1'b0, op: MUL_IDLE, finish: 1'b0};
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = S_RUN;
          step_next = MUL_TX;
        end
      end
      S_RUN: begin
        cmd.op = step;
        if (step == MUL_DH) state_next = S_DONE;
        else step_next = mul_op_t'(step + 4'd1);
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= MUL_IDLE;
    end else begin
      state <= state_next;
      step <= step_next;
    end
  end
endmodule
`default_nettype wire

[sv/mwmo_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module mwmo_datapath #(
  parameter int SINE_TABLE_DEPTH = mwmo_pkg::SineTableDepth
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mwmo_pkg::mwmo_cmd_t cmd,
  input  wire logic signed [15:0]  vel_x,
  input  wire logic signed [15:0]  vel_y,
  input  wire logic signed [15:0]  yaw_rate,
  input  wire logic                link_ok,
  input  wire logic [19:0]         trans_scale,
  input  wire logic [19:0]         rot_scale,
  input  wire logic [15:0]         tick_period,
  output logic [7:0]               wheel_cmd [4],
  output logic                     ok_q,
  output logic signed [31:0]       pos_x,
  output logic signed [31:0]       pos_y,
  output logic [15:0]              heading
);
  import mwmo_pkg::*;

  localparam int IdxW = $clog2(SINE_TABLE_DEPTH);

  // Quadrant folding per entry; the angle of each entry is a constant.
  logic signed [15:0] sine_rom [SINE_TABLE_DEPTH];
  for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_rom
    localparam longint unsigned D = SINE_TABLE_DEPTH;
    localparam longint unsigned U = 4 * i;
    localparam longint unsigned Fold = (U < D) ? U :
                                       (U < 2 * D) ? 2 * D - U :
                                       (U < 3 * D) ? U - 2 * D : 4 * D - U;
    localparam logic Neg = (U >= 2 * D);
    localparam longint unsigned XArg = ((Fold > D) ? D : Fold) * 64'd1686629713 / D;
    assign sine_rom[i] = sine_poly(XArg, Neg);
  end

  logic signed [15:0] vx, vy, wz;
  logic               ok;
  logic signed [19:0] trs, rts;
  logic [15:0]        per;
  logic signed [15:0] sn, cs;
  logic signed [37:0] tx, ty, rr;
  logic signed [32:0] gx, gy;
  logic signed [47:0] prod;
  logic signed [49:0] dxr, dyr;
  logic signed [32:0] wp;
  logic signed [31:0] pose_heading;
  logic signed [15:0] hc;
  logic [31:0]        sprod, cprod;
  logic [IdxW-1:0]    si, ci;
  logic signed [35:0] ma;
  logic signed [35:0] mb;
  logic signed [71:0] mfull;

  // Table index = floor(h * depth / 65536)
  assign hc = pose_heading[31:16] + 16'sh4000;
  assign sprod = {16'd0, pose_heading[31:16]} * 32'(SINE_TABLE_DEPTH);
  assign cprod = {16'd0, hc} * 32'(SINE_TABLE_DEPTH);
  assign si = sprod[16 +: IdxW];
  assign ci = cprod[16 +: IdxW];

  // Shared multiplier; both operands are 36 bits wide.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      MUL_TX:  begin ma = 36'(vx); mb = 36'($signed({1'b0, trs})); end
      MUL_TY:  begin ma = 36'(vy); mb = 36'($signed({1'b0, trs})); end
      MUL_R:   begin ma = 36'(wz); mb = 36'($signed({1'b0, rts})); end
      MUL_CX:  begin ma = 36'(cs); mb = 36'(vx); end
      MUL_SY:  begin ma = 36'(sn); mb = 36'(vy); end
      MUL_SX:  begin ma = 36'(sn); mb = 36'(vx); end
      MUL_CY:  begin ma = 36'(cs); mb = 36'(vy); end
      MUL_GXP: begin ma = 36'(gx); mb = 36'($signed({1'b0, per})); end
      MUL_GYP: begin ma = 36'(gy); mb = 36'($signed({1'b0, per})); end
      MUL_WP:  begin ma = 36'(wz); mb = 36'($signed({1'b0, per})); end
      MUL_DH:  begin ma = 36'(wp); mb = 36'(TurnPerRad); end
      default: ;
    endcase
  end
  assign mfull = ma * mb;
  assign prod = mfull[47:0];

  function automatic logic [7:0] wbyte(input logic signed [39:0] s);
    logic signed [39:0] v;
    v = s + (40'sd127 <<< 20);
    if (v >= (40'sd250 <<< 20)) return WheelMax;
    if (v < (40'sd7 <<< 20)) return WheelMin;
    return v[27:20];
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [49:0] d);
    logic signed [50:0] r;
    r = 51'(a) + 51'(d);
    if (r > 51'sd2147483647) return 32'sh7fffffff;
    if (r < -51'sd2147483648) return 32'sh80000000;
    return r[31:0];
  endfunction

  logic signed [39:0] etx, ety, er;
  assign etx = 40'(tx);
  assign ety = 40'(ty);
  assign er = 40'(rr);

  logic signed [63:0] dh_full;
  logic signed [63:0] dh_sum;
  assign dh_full = mfull[63:0];
  assign dh_sum = dh_full + 64'sd134217728;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vx <= vel_x; vy <= vel_y; wz <= yaw_rate; ok <= link_ok;
      trs <= trans_scale; rts <= rot_scale; per <= tick_period;
      sn <= sine_rom[si];
      cs <= sine_rom[ci];
    end
    unique case (cmd.op)
      MUL_TX:  tx <= prod[37:0];
      MUL_TY:  ty <= prod[37:0];
      MUL_R:   rr <= prod[37:0];
      MUL_CX:  gx <= 33'(prod);
      MUL_SY:  gx <= gx - 33'(prod);
      MUL_SX:  gy <= 33'(prod);
      MUL_CY:  gy <= gy + 33'(prod);
      MUL_GXP: dxr <= 50'(prod + 48'sd33554432) >>> 26;
      MUL_GYP: dyr <= 50'(prod + 48'sd33554432) >>> 26;
      MUL_WP:  wp <= prod[32:0];
      default: ;
    endcase
    if (cmd.finish) begin
      wheel_cmd[0] <= wbyte(-etx + ety + er);
      wheel_cmd[1] <= wbyte(etx + ety + er);
      wheel_cmd[2] <= wbyte(-etx - ety + er);
      wheel_cmd[3] <= wbyte(etx - ety + er);
      ok_q <= ok;
    end
  end

  // Pose state; updated on the final multiply when the link is up.
  always_ff @(posedge clk) begin
    if (rst) begin
      pose_heading <= '0;
      pos_x <= '0;
      pos_y <= '0;
    end else if (cmd.op == MUL_DH && ok) begin
      pose_heading <= pose_heading + dh_sum[59:28];
      pos_x <= sat_add(pos_x, dxr);
      pos_y <= sat_add(pos_y, dyr);
    end
  end
  assign heading = pose_heading[31:16];
endmodule
`default_nettype wire

[sv/mecanum_wheel_mixer_odometry_unit.sv]
// Mecanum wheel mixer with dead-reckoning odometry.
// Input stream (s_axis_*): one body velocity command per beat.
// Output stream (m_axis_*): four wheel command bytes plus the pose after the step.
// Config port: cfg_we / cfg_index / cfg_data; index 0 trans_scale,
//   1 rot_scale, 2 tick_period; other indexes are ignored.
// Sequence: after the accepting edge, one shared multiplier runs eleven
//   products in sequence, then the result is registered and m_axis_tvalid rises;
//   s_axis_tready is low while a beat is in progress, so a new beat is taken
//   only once the previous one has finished.
// The result register holds while m_axis_tready is low; the next input beat is
//   still taken and computed, but its result waits until the held beat leaves.
// Reset (rst, synchronous): pose and heading clear to zero, registers take
//   their default values, both streams go idle.
// When link_ok is low the wheel bytes are still produced, cmd_valid is 0 and
//   the pose is left unchanged.
// Sine table: SINE_TABLE_DEPTH entries per turn, built at elaboration.
`timescale 1ns / 1ps
`default_nettype none
`include "mecanum_wheel_mixer_odometry_unit_defines.svh"
module mecanum_wheel_mixer_odometry_unit #(
  parameter int SINE_TABLE_DEPTH = mwmo_pkg::SineTableDepth
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // vel_x[15:0], vel_y[31:16], yaw_rate[47:32]
  input  wire logic [47:0]  s_axis_tdata,
  // link_ok
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // wheel_cmd_0[7:0], _1[15:8], _2[23:16], _3[31:24], pos_x[63:32],
  // pos_y[95:64], heading[111:96]
  output logic [111:0]      m_axis_tdata,
  // cmd_valid
  output logic              m_axis_tuser,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [19:0]  cfg_data
);
  import mwmo_pkg::*;

  logic [19:0] trans_scale, rot_scale;
  logic [15:0] tick_period;
  mwmo_cmd_t   cmd;
  logic        busy;
  logic        in_fire;
  logic [7:0]  wheel_cmd [4];
  logic        ok_q;
  logic signed [31:0] pos_x, pos_y;
  logic [15:0] heading;

  always_ff @(posedge clk) begin
    if (rst) begin
      trans_scale <= TransReset;
      rot_scale <= RotReset;
      tick_period <= PeriodReset;
    end else if (cfg_we) begin
      priority case (cfg_index)
        RegTrans:  trans_scale <= cfg_data;
        RegRot:    rot_scale <= cfg_data;
        RegPeriod: tick_period <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  mwmo_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire),
    .out_free(!m_axis_tvalid || m_axis_tready),
    .cmd(cmd), .busy(busy)
  );

  mwmo_datapath #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .vel_x(s_axis_tdata[15:0]), .vel_y(s_axis_tdata[31:16]),
    .yaw_rate(s_axis_tdata[47:32]), .link_ok(s_axis_tuser),
    .trans_scale(trans_scale), .rot_scale(rot_scale), .tick_period(tick_period),
    .wheel_cmd(wheel_cmd), .ok_q(ok_q),
    .pos_x(pos_x), .pos_y(pos_y), .heading(heading)
  );

  // Output valid flag and pose hold registers; the wheel bytes come straight
  // from the datapath registers, which only change on the finish command.
  logic [31:0] hold_x, hold_y;
  logic [15:0] hold_h;
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (cmd.finish) begin
      hold_x <= pos_x;
      hold_y <= pos_y;
      hold_h <= heading;
    end
  end

  assign m_axis_tdata = {hold_h, hold_y, hold_x,
                         wheel_cmd[3], wheel_cmd[2], wheel_cmd[1], wheel_cmd[0]};
  assign m_axis_tuser = ok_q;

  `MWMO_ASSERT(a_no_accept_busy, busy |-> !in_fire, "input taken while busy")
  `MWMO_ASSERT(a_finish_free, cmd.finish |-> (!m_axis_tvalid || m_axis_tready),
    "result overwritten before taken")
  `MWMO_ASSERT(a_bytes_range, m_axis_tvalid |-> (m_axis_tdata[7:0] >= 8'd7 &&
    m_axis_tdata[7:0] <= 8'd250), "wheel byte out of range")
  `MWMO_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> !m_axis_tvalid, "valid after reset")
endmodule
`default_nettype wire
